FILE: rtl/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

`define LKV_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

`define LKV_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LKV_ASSERT(lbl, clk_s, rstn_s, prop, msg)

`define LKV_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Field widths, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int KEY_W  = 16;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic load;       // capture the input item
        logic lookup;     // compare keys, pick the target entry
        logic update;     // write data/key, rerank ages, issue data read
        logic cfg_write;  // capacity write transfer
    } lkv_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/busy: an item (cmd, key, write_value) transfers at a
//   rising edge with start high and busy low. cmd 0 is a get, 1 a put.
//   Each item gives one result (hit, read_value) on the ports for exactly one
//   cycle while done is high. The receiver cannot stall; the result is taken
//   in that cycle.
//   After the accepting edge an item passes the lookup, update and respond
//   states; done is high in respond, as the value RAM's read is registered.
//   A new item may transfer during the respond cycle, so the next item can
//   be taken while the last one's result is on the ports.
//   Capacity: a cfg_valid/cfg_ready transfer writes entries_in_use (0 acts
//   as 1, above ENTRIES acts as ENTRIES) and empties the cache. cfg_ready is
//   high only while no item is in flight.
//   Reset: rst_n clears the cache to empty with capacity min(16, ENTRIES);
//   no clearing pass, the first item may transfer right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              cmd,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [DATA_W-1:0] write_value,
    output logic                   done,
    output logic                   hit,
    output logic [DATA_W-1:0]      read_value,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  entries_in_use
);

    lkv_ctl_t ctl;

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready),
        .ctl       (ctl)
    );

    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .cmd            (cmd),
        .key            (key),
        .write_value    (write_value),
        .entries_in_use (entries_in_use),
        .hit            (hit),
        .read_value     (read_value)
    );

endmodule

`default_nettype wire

FILE: rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [ADDR_W-1:0]      raddr,
    output logic      [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences each item through lookup, update and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl
    import lkv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic cfg_valid,
    output logic      busy,
    output logic      done,
    output logic      cfg_ready,
    output lkv_ctl_t  ctl
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_LOOKUP  = 4'b0010,
        ST_UPDATE  = 4'b0100,
        ST_RESPOND = 4'b1000
    } lkv_state_t;

    lkv_state_t state_reg;
    lkv_state_t state_next;

    // the next item may be taken while the result is on the ports
    assign busy      = !((state_reg == ST_IDLE) || (state_reg == ST_RESPOND));
    assign done      = (state_reg == ST_RESPOND);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctl.load      = start && !busy;
        ctl.lookup    = (state_reg == ST_LOOKUP);
        ctl.update    = (state_reg == ST_UPDATE);
        ctl.cfg_write = cfg_valid && cfg_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                state_next = start ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lkv_dp.sv
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Parallel key match, fill count, recency ranks and the value RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lkv_dp
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lkv_ctl_t          ctl,
    input  wire logic              cmd,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [DATA_W-1:0] write_value,
    input  wire logic [CFG_W-1:0]  entries_in_use,
    output logic                   hit,
    output logic [DATA_W-1:0]      read_value
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;

    // valid entries are always 0..count-1: fills take the lowest free slot
    // and only a capacity write empties the cache
    logic [CW-1:0]     cap_reg;
    logic [CW-1:0]     count_reg;
    logic [KEY_W-1:0]  entry_key_reg [ENTRIES];
    logic [IW-1:0]     entry_age_reg [ENTRIES];

    logic              in_cmd_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic [DATA_W-1:0] in_wval_reg;

    logic [ENTRIES-1:0] tgt_onehot_reg;
    logic [IW-1:0]      tgt_idx_reg;
    logic [IW-1:0]      limit_reg;
    logic               hit_reg;
    logic               fresh_reg;

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] fill_vec;
    logic [ENTRIES-1:0] tgt_vec;
    logic               any_hit;
    logic               full;
    logic [IW-1:0]      tgt_idx;
    logic [IW-1:0]      tgt_age;
    logic [CW-1:0]      cap_clamped;
    logic               touch_en;
    logic               ram_we;
    logic               ram_re;
    logic [DATA_W-1:0]  ram_rdata;

    always_comb
    begin
        if (entries_in_use == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if (int'(entries_in_use) > ENTRIES)
        begin
            cap_clamped = CW'(ENTRIES);
        end
        else
        begin
            cap_clamped = CW'(entries_in_use);
        end
    end

    // lookup: all entries compared at once
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_vec[i]  = (CW'(i) < count_reg);
            match_vec[i]  = valid_vec[i] && (entry_key_reg[i] == in_key_reg);
            // ranks are a permutation when full: oldest holds cap-1
            victim_vec[i] = valid_vec[i] &&
                            (CW'(entry_age_reg[i]) == CW'(cap_reg - CW'(1)));
            fill_vec[i]   = (CW'(i) == count_reg);
        end
    end

    assign any_hit = |match_vec;
    assign full    = (count_reg == cap_reg);

    always_comb
    begin
        priority if (any_hit)
        begin
            tgt_vec = match_vec;
        end
        else if (!full)
        begin
            tgt_vec = fill_vec;
        end
        else
        begin
            tgt_vec = victim_vec;
        end
    end

    always_comb
    begin
        tgt_idx = '0;
        tgt_age = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tgt_vec[i])
            begin
                tgt_idx = tgt_idx | IW'(i);
                tgt_age = tgt_age | entry_age_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_cmd_reg  <= cmd;
            in_key_reg  <= key;
            in_wval_reg <= write_value;
        end
        if (ctl.lookup)
        begin
            tgt_onehot_reg <= tgt_vec;
            tgt_idx_reg    <= tgt_idx;
            limit_reg      <= tgt_age;
            hit_reg        <= any_hit;
            fresh_reg      <= !any_hit && !full;
        end
        if (ctl.update && (in_cmd_reg == CMD_PUT) && !hit_reg)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tgt_onehot_reg[i])
                begin
                    entry_key_reg[i] <= in_key_reg;
                end
            end
        end
    end

    // a get miss leaves the ranks alone
    assign touch_en = (in_cmd_reg == CMD_PUT) || hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CW'(CAP_RESET);
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_age_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.cfg_write)
            begin
                cap_reg   <= cap_clamped;
                count_reg <= '0;
            end
            else if (ctl.update && (in_cmd_reg == CMD_PUT) && fresh_reg)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (ctl.update && touch_en)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tgt_onehot_reg[i])
                    begin
                        entry_age_reg[i] <= '0;
                    end
                    else if (valid_vec[i] && (fresh_reg || (entry_age_reg[i] < limit_reg)))
                    begin
                        entry_age_reg[i] <= entry_age_reg[i] + IW'(1);
                    end
                end
            end
        end
    end

    assign ram_we = ctl.update && (in_cmd_reg == CMD_PUT);
    assign ram_re = ctl.update && (in_cmd_reg == CMD_GET) && hit_reg;

    lkv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx_reg),
        .wdata (in_wval_reg),
        .re    (ram_re),
        .raddr (tgt_idx_reg),
        .rdata (ram_rdata)
    );

    assign hit        = hit_reg;
    assign read_value = ((in_cmd_reg == CMD_GET) && hit_reg) ? ram_rdata : '0;

    `LKV_ASSERT(a_key_unique, clk, rst_n, $onehot0(match_vec), "two valid entries share a key")
    `LKV_ASSERT(a_count_cap, clk, rst_n, count_reg <= cap_reg, "fill count above capacity")
    `LKV_ASSERT_IMP(a_victim_one, clk, rst_n, ctl.lookup && !any_hit && full, $onehot(victim_vec), "full cache without a single oldest entry")

endmodule

`default_nettype wire

FILE: tb/lru_cache_checker.sv
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Watches the item, result and capacity channels of the cache, keeps its own
// copy of the entries and recency ranks, predicts each result at item
// transfer and compares it with the result the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_cache_checker
    import lkv_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              cmd,
    input  logic [KEY_W-1:0]  key,
    input  logic [DATA_W-1:0] write_value,
    input  logic              done,
    input  logic              hit,
    input  logic [DATA_W-1:0] read_value,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  entries_in_use,
    output int                fail_count,
    output int                outstanding
);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } lookup_result_t;

    logic              slot_valid [NUM_ENTRIES];
    logic [KEY_W-1:0]  slot_key   [NUM_ENTRIES];
    logic [DATA_W-1:0] slot_data  [NUM_ENTRIES];
    logic [3:0]        slot_rank  [NUM_ENTRIES];
    logic [CFG_W-1:0]  capacity;

    lookup_result_t expected_lookups [$];
    int errors;

    function automatic int enabled_slots();
        int n;
        n = capacity;
        if (n < 1) n = 1;
        if (n > NUM_ENTRIES) n = NUM_ENTRIES;
        return n;
    endfunction

    task automatic empty_cache();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_rank[i]  = '0;
        end
    endtask

    // Rank 0 is the most recent; a freshly filled slot counts as the oldest.
    task automatic promote(input int idx, input bit fresh);
        int n;
        int limit;
        n = enabled_slots();
        limit = fresh ? 32'hFFFF : int'(slot_rank[idx]);
        for (int i = 0; i < n; i++)
        begin
            if (i != idx && slot_valid[i] && int'(slot_rank[i]) < limit)
                slot_rank[i] = slot_rank[i] + 4'd1;
        end
        slot_rank[idx] = '0;
    endtask

    task automatic access_cache(input logic op, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] v, output lookup_result_t res);
        int n;
        int found;
        int empty_slot;
        int victim;
        n = enabled_slots();
        found = -1;
        empty_slot = -1;
        victim = 0;
        for (int i = 0; i < n; i++)
        begin
            if (found < 0 && slot_valid[i] && slot_key[i] == k) found = i;
            if (empty_slot < 0 && !slot_valid[i]) empty_slot = i;
        end
        res.hit = (found >= 0);
        res.value = '0;
        if (op == CMD_GET)
        begin
            if (found >= 0)
            begin
                res.value = slot_data[found];
                promote(found, 1'b0);
            end
        end
        else if (found >= 0)
        begin
            slot_data[found] = v;
            promote(found, 1'b0);
        end
        else if (empty_slot >= 0)
        begin
            slot_valid[empty_slot] = 1'b1;
            slot_key[empty_slot]   = k;
            slot_data[empty_slot]  = v;
            promote(empty_slot, 1'b1);
        end
        else
        begin
            for (int i = 1; i < n; i++)
            begin
                if (slot_rank[i] > slot_rank[victim]) victim = i;
            end
            slot_key[victim]  = k;
            slot_data[victim] = v;
            promote(victim, 1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t predicted;
        lookup_result_t oldest;
        if (!rst_n)
        begin
            capacity = 5'd16;
            empty_cache();
            expected_lookups.delete();
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // retire the result first: an item transferring at this edge is younger
            if (done)
            begin
                if (expected_lookups.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result: hit %0d read_value %08h",
                                 $realtime, hit, read_value);
                    errors++;
                end
                else
                begin
                    oldest = expected_lookups.pop_front();
                    if (hit !== oldest.hit || read_value !== oldest.value)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch: hit exp %0d got %0d, read_value exp %08h got %08h",
                                     $realtime, oldest.hit, hit, oldest.value, read_value);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                capacity = entries_in_use;
                empty_cache();
            end
            if (start && !busy)
            begin
                access_cache(cmd, key, write_value, predicted);
                expected_lookups.push_back(predicted);
            end
            fail_count <= errors;
            outstanding <= expected_lookups.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Directed gets and puts over key and value extremes, updates and evictions,
// then random phases at several capacities, the out-of-range ones included,
// with random start gaps in all but the last. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lkv_pkg::*;

    localparam int NUM_ENTRIES     = 16;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int STALL_LIMIT     = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] write_value;
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  entries_in_use;

    int fail_count;
    int outstanding;
    int quiet_cycles;
    int gap_pct;

    lru_key_value_cache #(
        .ENTRIES(NUM_ENTRIES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .key            (key),
        .write_value    (write_value),
        .done           (done),
        .hit            (hit),
        .read_value     (read_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .entries_in_use (entries_in_use)
    );

    lru_cache_checker #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_lru_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .key            (key),
        .write_value    (write_value),
        .done           (done),
        .hit            (hit),
        .read_value     (read_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .entries_in_use (entries_in_use),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Leaves start high on return so back-to-back items need no second drive.
    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] v);
        start       <= 1'b1;
        cmd         <= op;
        key         <= k;
        write_value <= v;
        do @(posedge clk); while (busy);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg_valid      <= 1'b1;
        entries_in_use <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] cap, input bit allow_gaps);
        int slots;
        int roll;
        logic [KEY_W-1:0]  key_base;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
        set_capacity(cap);
        slots = (cap == 0) ? 1 : (cap > NUM_ENTRIES) ? NUM_ENTRIES : int'(cap);
        key_base = KEY_W'($urandom);
        gap_pct = allow_gaps ? $urandom_range(0, 40) : 0;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            // keys mostly from a pool of 2 * slots + 2 keys: hits and evictions
            roll = $urandom_range(0, 99);
            if (roll < 8)
                k = KEY_W'($urandom);
            else
                k = key_base ^ KEY_W'($urandom_range(0, 2 * slots + 1));
            roll = $urandom_range(0, 99);
            if (roll < 5)
                v = '0;
            else if (roll < 10)
                v = '1;
            else
                v = $urandom;
            send_item($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, v);
            random_gap();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_GET;
        key            = '0;
        write_value    = '0;
        cfg_valid      = 1'b0;
        entries_in_use = '0;
        quiet_cycles   = 0;
        gap_pct        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty cache, key and value extremes, update in place
        send_item(CMD_GET, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_PUT, 16'h0000, 32'h0000_0000);
        send_item(CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_GET, 16'h0000, 32'h0000_0000);
        send_item(CMD_GET, 16'hFFFF, 32'h0000_0000);
        send_item(CMD_PUT, 16'hFFFF, 32'h1234_5678);
        send_item(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_GET, 16'h0005, 32'h0000_0000);

        // capacity two: a write empties the cache, a get moves an entry ahead of eviction
        set_capacity(5'd2);
        send_item(CMD_GET, 16'h0000, 32'h0000_0000);
        send_item(CMD_PUT, 16'h0001, 32'hAAAA_0001);
        send_item(CMD_PUT, 16'h0002, 32'hBBBB_0002);
        send_item(CMD_GET, 16'h0001, 32'h0000_0000);
        send_item(CMD_PUT, 16'h0003, 32'hCCCC_0003);
        send_item(CMD_GET, 16'h0002, 32'h0000_0000);
        send_item(CMD_GET, 16'h0001, 32'h0000_0000);
        send_item(CMD_GET, 16'h0003, 32'h0000_0000);
        send_item(CMD_PUT, 16'h0001, 32'h5555_5555);
        send_item(CMD_PUT, 16'h0004, 32'h6666_6666);
        send_item(CMD_GET, 16'h0003, 32'h0000_0000);
        send_item(CMD_GET, 16'h0001, 32'h0000_0000);

        random_phase(5'd16, 1'b1);
        random_phase(5'd1, 1'b1);
        random_phase(5'd0, 1'b1);
        random_phase(5'd31, 1'b1);
        random_phase(5'd2, 1'b1);
        random_phase(5'd5, 1'b1);
        random_phase(CFG_W'($urandom_range(3, 15)), 1'b1);
        random_phase(5'd17, 1'b1);
        random_phase(CFG_W'($urandom_range(0, 31)), 1'b1);
        random_phase(5'd16, 1'b0);

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
